// ===== rtl/core/lih_pkg.sv =====
// ============================================================================
// lih_pkg
// Shared types and fixed widths for the line intersection block.
// ============================================================================
package lih_pkg;

    // Signed coordinate width of the input points.
    localparam int COORD_BITS = 16;
    // Width of every input coordinate field.
    localparam int IN_W  = COORD_BITS;
    // Width of every output coordinate field.
    localparam int OUT_W = 48;
    // Quotient bits produced by the divider chain (one guard bit above OUT_W).
    localparam int QUO_W = OUT_W + 1;

    // One input item: two lines, each given by two points.
    typedef struct packed {
        logic signed [IN_W-1:0] line_a_start_x;
        logic signed [IN_W-1:0] line_a_start_y;
        logic signed [IN_W-1:0] line_a_end_x;
        logic signed [IN_W-1:0] line_a_end_y;
        logic signed [IN_W-1:0] line_b_start_x;
        logic signed [IN_W-1:0] line_b_start_y;
        logic signed [IN_W-1:0] line_b_end_x;
        logic signed [IN_W-1:0] line_b_end_y;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
        logic                    not_representable;
    } t_out_item;

    // Control that travels alongside the data through the divider cells.
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic bad;
    } t_div_ctrl;

endpackage

// ===== rtl/core/lih_front.sv =====
// ============================================================================
// lih_front
// Six-stage front end: homogeneous line forms, their cross product, and the
// magnitudes, signs and range pre-check that feed the divider chain.
// ============================================================================
module lih_front
    import lih_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DW         = 2 * COORD_BITS + 3,
    parameter int RW         = DW + QUO_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_in_item          i_item,
    output logic [RW-1:0]     o_rem_x,
    output logic [RW-1:0]     o_rem_y,
    output logic [DW-1:0]     o_div,
    output t_div_ctrl         o_ctrl
);

    localparam int CW   = COORD_BITS;
    localparam int EXTW = (CW > IN_W) ? CW : IN_W;
    localparam int DXW  = CW + 1;
    localparam int PW   = 2 * CW;
    localparam int LCW  = 2 * CW + 1;
    localparam int T3W  = 3 * CW + 2;
    localparam int T5W  = 2 * CW + 2;
    localparam int HXW  = 3 * CW + 3;
    localparam int NST  = 6;

    logic [IN_W-1:0]        w_raw [8];
    logic signed [CW-1:0]   w_c   [8];
    logic [EXTW-1:0]        w_ext [8];

    logic [NST-1:0]         r_v;

    logic signed [DXW-1:0]  r_la, r_lb, r_ma, r_mb, n_la, n_lb, n_ma, n_mb;
    logic signed [PW-1:0]   r_p1, r_p2, r_p3, r_p4, n_p1, n_p2, n_p3, n_p4;
    logic signed [DXW-1:0]  r2_la, r2_lb, r2_ma, r2_mb;
    logic signed [LCW-1:0]  r_lc, r_mc, n_lc, n_mc;
    logic signed [T3W-1:0]  r_t1, r_t2, r_t3, r_t4, n_t1, n_t2, n_t3, n_t4;
    logic signed [T5W-1:0]  r_t5, r_t6, n_t5, n_t6;
    logic signed [HXW-1:0]  r_hx, r_hy, n_hx, n_hy;
    logic signed [DW-1:0]   r_hw, n_hw;
    logic [HXW-1:0]         r_nx, r_ny, n_nx, n_ny;
    logic [DW-1:0]          r_d, n_d;
    logic                   r_neg_x, r_neg_y, r_zero;
    logic [RW-1:0]          r_rx, r_ry, n_rx, n_ry;
    logic [DW-1:0]          r_d6;
    logic                   r_neg_x6, r_neg_y6, r_bad, n_bad;

    // Take the low COORD_BITS bits of each field as a signed coordinate.
    assign w_raw[0] = i_item.line_a_start_x;
    assign w_raw[1] = i_item.line_a_start_y;
    assign w_raw[2] = i_item.line_a_end_x;
    assign w_raw[3] = i_item.line_a_end_y;
    assign w_raw[4] = i_item.line_b_start_x;
    assign w_raw[5] = i_item.line_b_start_y;
    assign w_raw[6] = i_item.line_b_end_x;
    assign w_raw[7] = i_item.line_b_end_y;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_ext[i] = EXTW'(w_raw[i]);
            w_c[i]   = signed'(w_ext[i][CW-1:0]);
        end
    end

    // Stage one: direction components and the point products.
    always_comb begin
        n_la = DXW'(w_c[1]) - DXW'(w_c[3]);
        n_lb = DXW'(w_c[2]) - DXW'(w_c[0]);
        n_ma = DXW'(w_c[5]) - DXW'(w_c[7]);
        n_mb = DXW'(w_c[6]) - DXW'(w_c[4]);
        n_p1 = PW'(w_c[0]) * PW'(w_c[3]);
        n_p2 = PW'(w_c[2]) * PW'(w_c[1]);
        n_p3 = PW'(w_c[4]) * PW'(w_c[7]);
        n_p4 = PW'(w_c[6]) * PW'(w_c[5]);
    end

    // Stage two: constant terms of both lines.
    always_comb begin
        n_lc = LCW'(r_p1) - LCW'(r_p2);
        n_mc = LCW'(r_p3) - LCW'(r_p4);
    end

    // Stage three: products of the line cross product.
    always_comb begin
        n_t1 = T3W'(r2_lb) * T3W'(r_mc);
        n_t2 = T3W'(r2_mb) * T3W'(r_lc);
        n_t3 = T3W'(r2_ma) * T3W'(r_lc);
        n_t4 = T3W'(r2_la) * T3W'(r_mc);
        n_t5 = T5W'(r2_la) * T5W'(r2_mb);
        n_t6 = T5W'(r2_ma) * T5W'(r2_lb);
    end

    // Stage four: homogeneous x, y and w.
    always_comb begin
        n_hx = HXW'(r_t1) - HXW'(r_t2);
        n_hy = HXW'(r_t3) - HXW'(r_t4);
        n_hw = DW'(r_t5) - DW'(r_t6);
    end

    // Stage five: magnitudes for the unsigned divider.
    always_comb begin
        n_nx = r_hx[HXW-1] ? HXW'(-r_hx) : HXW'(r_hx);
        n_ny = r_hy[HXW-1] ? HXW'(-r_hy) : HXW'(r_hy);
        n_d  = r_hw[DW-1]  ? DW'(-r_hw)  : DW'(r_hw);
    end

    // Stage six: scale the numerators and flag quotients that cannot fit.
    always_comb begin
        n_rx  = RW'(r_nx) << FRAC_BITS;
        n_ry  = RW'(r_ny) << FRAC_BITS;
        n_bad = r_zero || (n_rx >= (RW'(r_d) << QUO_W)) || (n_ry >= (RW'(r_d) << QUO_W));
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // Stage data registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la     <= n_la;
            r_lb     <= n_lb;
            r_ma     <= n_ma;
            r_mb     <= n_mb;
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_p3     <= n_p3;
            r_p4     <= n_p4;
            r2_la    <= r_la;
            r2_lb    <= r_lb;
            r2_ma    <= r_ma;
            r2_mb    <= r_mb;
            r_lc     <= n_lc;
            r_mc     <= n_mc;
            r_t1     <= n_t1;
            r_t2     <= n_t2;
            r_t3     <= n_t3;
            r_t4     <= n_t4;
            r_t5     <= n_t5;
            r_t6     <= n_t6;
            r_hx     <= n_hx;
            r_hy     <= n_hy;
            r_hw     <= n_hw;
            r_nx     <= n_nx;
            r_ny     <= n_ny;
            r_d      <= n_d;
            r_neg_x  <= r_hx[HXW-1] ^ r_hw[DW-1];
            r_neg_y  <= r_hy[HXW-1] ^ r_hw[DW-1];
            r_zero   <= (r_hw == '0);
            r_rx     <= n_rx;
            r_ry     <= n_ry;
            r_d6     <= r_d;
            r_neg_x6 <= r_neg_x;
            r_neg_y6 <= r_neg_y;
            r_bad    <= n_bad;
        end
    end

    assign o_rem_x      = r_rx;
    assign o_rem_y      = r_ry;
    assign o_div        = r_d6;
    assign o_ctrl.valid = r_v[NST-1];
    assign o_ctrl.neg_x = r_neg_x6;
    assign o_ctrl.neg_y = r_neg_y6;
    assign o_ctrl.bad   = r_bad;

endmodule

// ===== rtl/core/lih_div_cell.sv =====
// ============================================================================
// lih_div_cell
// One restoring division step for the x and y lanes, deciding quotient bit
// SHIFT and handing remainders on to the next cell.
// ============================================================================
module lih_div_cell
    import lih_pkg::*;
#(
    parameter int DW    = 35,
    parameter int RW    = DW + QUO_W,
    parameter int SHIFT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_div_ctrl         i_ctrl,
    input  logic [RW-1:0]     i_rem_x,
    input  logic [RW-1:0]     i_rem_y,
    input  logic [QUO_W-1:0]  i_quo_x,
    input  logic [QUO_W-1:0]  i_quo_y,
    input  logic [DW-1:0]     i_div,
    output t_div_ctrl         o_ctrl,
    output logic [RW-1:0]     o_rem_x,
    output logic [RW-1:0]     o_rem_y,
    output logic [QUO_W-1:0]  o_quo_x,
    output logic [QUO_W-1:0]  o_quo_y,
    output logic [DW-1:0]     o_div
);

    logic [RW-1:0]    w_dsh;
    logic [RW-1:0]    n_rem_x, n_rem_y;
    logic [QUO_W-1:0] n_quo_x, n_quo_y;
    t_div_ctrl        r_ctrl;
    logic [RW-1:0]    r_rem_x, r_rem_y;
    logic [QUO_W-1:0] r_quo_x, r_quo_y;
    logic [DW-1:0]    r_div;

    // Trial subtraction of the shifted divisor in each lane.
    always_comb begin
        w_dsh   = RW'(i_div) << SHIFT;
        n_rem_x = i_rem_x;
        n_rem_y = i_rem_y;
        n_quo_x = i_quo_x;
        n_quo_y = i_quo_y;
        if (i_rem_x >= w_dsh) begin
            n_rem_x = i_rem_x - w_dsh;
            n_quo_x = i_quo_x | (QUO_W'(1) << SHIFT);
        end
        if (i_rem_y >= w_dsh) begin
            n_rem_y = i_rem_y - w_dsh;
            n_quo_y = i_quo_y | (QUO_W'(1) << SHIFT);
        end
    end

    // Control register; only the valid bit needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_quo_x <= n_quo_x;
            r_quo_y <= n_quo_y;
            r_div   <= i_div;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;
    assign o_div   = r_div;

endmodule

// ===== rtl/core/line_intersection_homogeneous_top.sv =====
// ============================================================================
// line_intersection_homogeneous_top
// Intersection of two lines in homogeneous form with a pipelined divider.
// ============================================================================
// Usage:
// An item on the input channel carries two lines, each as two points of
// signed coordinates. One result transfer follows per input transfer: the
// crossing point in signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero, or a not_representable flag with zero coordinates
// when the lines are parallel or degenerate or a quotient leaves the
// 48-bit range.
// The block is fully pipelined and accepts one item every cycle unless the
// output stalls. It has six front-end stages (point products, line cross
// product, magnitudes and range check), a chain of 49 divider cells, one per
// quotient bit, and the output register.
// The whole pipeline advances together; when the receiver holds off ready
// with a result waiting, every stage holds and o_in_ready falls in the same
// cycle. Reset clears the valid bits only; no item is in flight after it.
// ============================================================================
module line_intersection_homogeneous_top
    import lih_pkg::*;
#(
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int DW = 2 * COORD_BITS + 3;
    localparam int RW = DW + QUO_W;

    logic             w_en;
    t_div_ctrl        w_ctrl  [QUO_W+1];
    logic [RW-1:0]    w_rem_x [QUO_W+1];
    logic [RW-1:0]    w_rem_y [QUO_W+1];
    logic [QUO_W-1:0] w_quo_x [QUO_W+1];
    logic [QUO_W-1:0] w_quo_y [QUO_W+1];
    logic [DW-1:0]    w_div   [QUO_W+1];

    logic             r_out_valid;
    t_out_item        r_out, n_out;
    logic             w_ok_x, w_ok_y, w_ok;
    logic [QUO_W-1:0] w_qx, w_qy;
    logic [QUO_W-1:0] w_lim;

    // The pipeline moves whenever the output register is free or being taken.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Front end.
    lih_front #(
        .FRAC_BITS  (FRAC_BITS),
        .DW         (DW),
        .RW         (RW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_rem_x (w_rem_x[0]),
        .o_rem_y (w_rem_y[0]),
        .o_div   (w_div[0]),
        .o_ctrl  (w_ctrl[0])
    );

    assign w_quo_x[0] = '0;
    assign w_quo_y[0] = '0;

    // Divider chain, most significant quotient bit first.
    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        lih_div_cell #(
            .DW    (DW),
            .RW    (RW),
            .SHIFT (QUO_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[g]),
            .i_rem_x (w_rem_x[g]),
            .i_rem_y (w_rem_y[g]),
            .i_quo_x (w_quo_x[g]),
            .i_quo_y (w_quo_y[g]),
            .i_div   (w_div[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_rem_x (w_rem_x[g+1]),
            .o_rem_y (w_rem_y[g+1]),
            .o_quo_x (w_quo_x[g+1]),
            .o_quo_y (w_quo_y[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    // Range check against the signed output limits and sign restore.
    always_comb begin
        w_qx   = w_quo_x[QUO_W];
        w_qy   = w_quo_y[QUO_W];
        w_lim  = QUO_W'(1) << (OUT_W - 1);
        w_ok_x = w_ctrl[QUO_W].neg_x ? (w_qx <= w_lim) : (w_qx < w_lim);
        w_ok_y = w_ctrl[QUO_W].neg_y ? (w_qy <= w_lim) : (w_qy < w_lim);
        w_ok   = !w_ctrl[QUO_W].bad && w_ok_x && w_ok_y;
        n_out.cross_x           = '0;
        n_out.cross_y           = '0;
        n_out.not_representable = !w_ok;
        if (w_ok) begin
            n_out.cross_x = w_ctrl[QUO_W].neg_x ? OUT_W'(-w_qx) : OUT_W'(w_qx);
            n_out.cross_y = w_ctrl[QUO_W].neg_y ? OUT_W'(-w_qy) : OUT_W'(w_qy);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctrl[QUO_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A flagged result always carries zero coordinates.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.not_representable) |->
        (o_out_data.cross_x == '0 && o_out_data.cross_y == '0))
        else $error("flagged result with non-zero coordinates");

    // An item leaving the last divider cell reaches the output register.
    a_chain_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl[QUO_W].valid && w_en) |=> o_out_valid)
        else $error("item lost between divider chain and output");

    // While stalled, the divider chain holds its items.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> ($stable(w_ctrl[0].valid) && $stable(w_ctrl[QUO_W].valid)))
        else $error("pipeline advanced during a stall");

endmodule
